>>> design/assert_macros.svh
// Assertion macros shared by the checker files of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent property, sampled on the rising clock, off while reset is low.
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be seen on a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

>>> design/rwt_pkg.sv
// Shared constants, payload types and controller/datapath interface types.
`timescale 1ns / 1ps
package rwt_pkg;

	localparam int SLOTS = 32;
	localparam int IDX_W = $clog2(SLOTS);
	localparam int CNT_W = $clog2(SLOTS + 1);

	localparam int CMD_W       = 2;
	localparam int TIME_W      = 32;
	localparam int SEQ_W       = 8;
	localparam int OFFSET_W    = 31;
	localparam int KIND_W      = 3;
	localparam int SLOT_INDEX_W = 5;
	localparam int COUNT_W     = 6;

	localparam int TIMEOUT_W = 16;
	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd4000;

	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic [PADDR_W-3:0] REG_TIMEOUT = '0;

	localparam logic [CMD_W-1:0] CMD_TICK = 2'd0;
	localparam logic [CMD_W-1:0] CMD_ADD  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_ACK  = 2'd2;

	localparam logic [KIND_W-1:0] KIND_RESEND    = 3'd0;
	localparam logic [KIND_W-1:0] KIND_ADDED     = 3'd1;
	localparam logic [KIND_W-1:0] KIND_REJECTED  = 3'd2;
	localparam logic [KIND_W-1:0] KIND_ACK_DONE  = 3'd3;
	localparam logic [KIND_W-1:0] KIND_TICK_DONE = 3'd4;

	typedef struct packed {
		logic [CMD_W-1:0]    cmd;
		logic [TIME_W-1:0]   now_ms;
		logic [SEQ_W-1:0]    seq_number;
		logic [OFFSET_W-1:0] file_offset;
	} in_item_t;

	typedef struct packed {
		logic [KIND_W-1:0]       kind;
		logic [SLOT_INDEX_W-1:0] slot_index;
		logic [SEQ_W-1:0]        slot_seq;
		logic [OFFSET_W-1:0]     slot_file_offset;
		logic [COUNT_W-1:0]      count;
		logic                    has_free;
		logic                    all_empty;
		logic                    last;
	} out_item_t;

	// One entry of the slot RAM.
	typedef struct packed {
		logic [SEQ_W-1:0]    seq;
		logic [TIME_W-1:0]   stamp;
		logic [OFFSET_W-1:0] offset;
	} slot_t;

	typedef struct packed {
		logic              load;
		logic              idx_clr;
		logic              idx_inc;
		logic              ram_rd;
		logic              restamp;
		logic              add_slot;
		logic              ack_clr;
		logic              match_take;
		logic              free_slot;
		logic              emit;
		logic [KIND_W-1:0] kind;
	} dp_cmd_t;

	typedef struct packed {
		logic cur_valid;
		logic idx_last;
		logic expired;
		logic seq_hit;
		logic off_le;
		logic found;
		logic full;
		logic out_free;
	} dp_sts_t;

endpackage

>>> design/rwt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module rwt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> design/rwt_ctrl.sv
// Sequencer that walks the slot table for tick, add and ack commands.
`timescale 1ns / 1ps
module rwt_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic [rwt_pkg::CMD_W-1:0]   in_cmd,
	input  rwt_pkg::dp_sts_t            sts,
	output logic                        in_ready,
	output rwt_pkg::dp_cmd_t            cmd
);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_T_RD   = 4'd1;
	localparam logic [3:0] S_T_EV   = 4'd2;
	localparam logic [3:0] S_T_DONE = 4'd3;
	localparam logic [3:0] S_ADD    = 4'd4;
	localparam logic [3:0] S_K1_RD  = 4'd5;
	localparam logic [3:0] S_K1_EV  = 4'd6;
	localparam logic [3:0] S_K2_RD  = 4'd7;
	localparam logic [3:0] S_K2_EV  = 4'd8;
	localparam logic [3:0] S_K_DONE = 4'd9;

	logic [3:0] state_q;
	logic [3:0] state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load    = 1'b1;
					cmd.idx_clr = 1'b1;
					unique case (in_cmd)
						rwt_pkg::CMD_TICK: state_d = S_T_RD;
						rwt_pkg::CMD_ADD:  state_d = S_ADD;
						rwt_pkg::CMD_ACK: begin
							cmd.ack_clr = 1'b1;
							state_d     = S_K1_RD;
						end
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_T_RD: begin
				if (sts.cur_valid) begin
					cmd.ram_rd = 1'b1;
					state_d    = S_T_EV;
				end else if (sts.idx_last) begin
					state_d = S_T_DONE;
				end else begin
					cmd.idx_inc = 1'b1;
				end
			end
			S_T_EV: begin
				// hold an expired slot until the output register can take its resend
				if (!(sts.expired && !sts.out_free)) begin
					if (sts.expired) begin
						cmd.restamp = 1'b1;
						cmd.emit    = 1'b1;
						cmd.kind    = rwt_pkg::KIND_RESEND;
					end
					if (sts.idx_last) begin
						state_d = S_T_DONE;
					end else begin
						cmd.idx_inc = 1'b1;
						state_d     = S_T_RD;
					end
				end
			end
			S_T_DONE: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					cmd.kind = rwt_pkg::KIND_TICK_DONE;
					state_d  = S_IDLE;
				end
			end
			S_ADD: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					if (sts.full) begin
						cmd.kind = rwt_pkg::KIND_REJECTED;
					end else begin
						cmd.add_slot = 1'b1;
						cmd.kind     = rwt_pkg::KIND_ADDED;
					end
					state_d = S_IDLE;
				end
			end
			S_K1_RD: begin
				if (sts.cur_valid) begin
					cmd.ram_rd = 1'b1;
					state_d    = S_K1_EV;
				end else if (sts.idx_last) begin
					if (sts.found) begin
						cmd.idx_clr = 1'b1;
						state_d     = S_K2_RD;
					end else begin
						state_d = S_K_DONE;
					end
				end else begin
					cmd.idx_inc = 1'b1;
				end
			end
			S_K1_EV: begin
				// later matches overwrite the limit: the highest index wins
				cmd.match_take = sts.seq_hit;
				if (sts.idx_last) begin
					if (sts.found || sts.seq_hit) begin
						cmd.idx_clr = 1'b1;
						state_d     = S_K2_RD;
					end else begin
						state_d = S_K_DONE;
					end
				end else begin
					cmd.idx_inc = 1'b1;
					state_d     = S_K1_RD;
				end
			end
			S_K2_RD: begin
				if (sts.cur_valid) begin
					cmd.ram_rd = 1'b1;
					state_d    = S_K2_EV;
				end else if (sts.idx_last) begin
					state_d = S_K_DONE;
				end else begin
					cmd.idx_inc = 1'b1;
				end
			end
			S_K2_EV: begin
				cmd.free_slot = sts.off_le;
				if (sts.idx_last) begin
					state_d = S_K_DONE;
				end else begin
					cmd.idx_inc = 1'b1;
					state_d     = S_K2_RD;
				end
			end
			S_K_DONE: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					cmd.kind = rwt_pkg::KIND_ACK_DONE;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> design/rwt_datapath.sv
// Slot table datapath: valid bits, slot RAM, scan index, counters, result register.
`timescale 1ns / 1ps
module rwt_datapath (
	input  logic                            clk,
	input  logic                            arst_n,
	input  rwt_pkg::dp_cmd_t                cmd,
	input  rwt_pkg::in_item_t               in_item,
	input  logic [rwt_pkg::TIMEOUT_W-1:0]   timeout_ms,
	input  logic                            out_ready,
	output logic                            out_valid,
	output rwt_pkg::out_item_t              out_item,
	output rwt_pkg::dp_sts_t                sts
);

	localparam int IDX_W  = rwt_pkg::IDX_W;
	localparam int CNT_W  = rwt_pkg::CNT_W;
	localparam int SLOT_W = $bits(rwt_pkg::slot_t);

	rwt_pkg::in_item_t              item_q;
	logic [rwt_pkg::SLOTS-1:0]      valid_q;
	logic [IDX_W-1:0]               idx_q;
	logic [CNT_W-1:0]               cnt_q;
	logic [CNT_W-1:0]               cnt_nx;
	logic [CNT_W-1:0]               freed_q;
	logic                           found_q;
	logic [rwt_pkg::OFFSET_W-1:0]   limit_q;
	logic                           out_valid_q;
	rwt_pkg::out_item_t             out_q;
	rwt_pkg::out_item_t             res;

	logic [IDX_W-1:0]               free_idx;
	logic                           ram_we;
	logic [IDX_W-1:0]               ram_waddr;
	rwt_pkg::slot_t                 ram_wslot;
	logic [SLOT_W-1:0]              ram_rbits;
	rwt_pkg::slot_t                 rd_slot;
	logic [rwt_pkg::SEQ_W-1:0]      acked_seq;

	assign rd_slot   = ram_rbits;
	assign acked_seq = item_q.seq_number - rwt_pkg::SEQ_W'(1);

	// lowest free slot
	always_comb begin
		free_idx = '0;
		for (int i = rwt_pkg::SLOTS - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_idx = IDX_W'(i);
			end
		end
	end

	assign ram_we    = cmd.restamp || cmd.add_slot;
	assign ram_waddr = cmd.add_slot ? free_idx : idx_q;
	always_comb begin
		if (cmd.add_slot) begin
			ram_wslot.seq    = item_q.seq_number;
			ram_wslot.stamp  = item_q.now_ms;
			ram_wslot.offset = item_q.file_offset;
		end else begin
			ram_wslot.seq    = rd_slot.seq;
			ram_wslot.stamp  = item_q.now_ms;
			ram_wslot.offset = rd_slot.offset;
		end
	end

	rwt_ram #(
		.WIDTH(SLOT_W),
		.DEPTH(rwt_pkg::SLOTS)
	) u_slot_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wslot),
		.re    (cmd.ram_rd),
		.raddr (idx_q),
		.rdata (ram_rbits)
	);

	always_comb begin
		if (cmd.add_slot) begin
			cnt_nx = cnt_q + CNT_W'(1);
		end else if (cmd.free_slot) begin
			cnt_nx = cnt_q - CNT_W'(1);
		end else begin
			cnt_nx = cnt_q;
		end
	end

	assign sts.cur_valid = valid_q[idx_q];
	assign sts.idx_last  = (idx_q == IDX_W'(rwt_pkg::SLOTS - 1));
	assign sts.expired   = ({1'b0, rd_slot.stamp} + (rwt_pkg::TIME_W + 1)'(timeout_ms))
		< {1'b0, item_q.now_ms};
	assign sts.seq_hit   = (rd_slot.seq == acked_seq);
	assign sts.off_le    = (rd_slot.offset <= limit_q);
	assign sts.found     = found_q;
	assign sts.full      = &valid_q;
	assign sts.out_free  = !out_valid_q || out_ready;

	// result fields; flags reflect the table after this cycle's update
	always_comb begin
		res           = '0;
		res.kind      = cmd.kind;
		res.has_free  = (cnt_nx != CNT_W'(rwt_pkg::SLOTS));
		res.all_empty = (cnt_nx == '0);
		res.last      = (cmd.kind != rwt_pkg::KIND_RESEND);
		unique case (cmd.kind)
			rwt_pkg::KIND_RESEND: begin
				res.slot_index       = rwt_pkg::SLOT_INDEX_W'(idx_q);
				res.slot_seq         = rd_slot.seq;
				res.slot_file_offset = rd_slot.offset;
			end
			rwt_pkg::KIND_ADDED: begin
				res.slot_index       = rwt_pkg::SLOT_INDEX_W'(free_idx);
				res.slot_seq         = item_q.seq_number;
				res.slot_file_offset = item_q.file_offset;
			end
			rwt_pkg::KIND_ACK_DONE:  res.count = rwt_pkg::COUNT_W'(freed_q);
			rwt_pkg::KIND_TICK_DONE: res.count = rwt_pkg::COUNT_W'(cnt_q);
			default: res.count = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= in_item;
		end
		if (cmd.match_take) begin
			limit_q <= rd_slot.offset;
		end
		if (cmd.emit) begin
			out_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			idx_q       <= '0;
			cnt_q       <= '0;
			freed_q     <= '0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.idx_clr) begin
				idx_q <= '0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + IDX_W'(1);
			end
			if (cmd.add_slot) begin
				valid_q[free_idx] <= 1'b1;
			end else if (cmd.free_slot) begin
				valid_q[idx_q] <= 1'b0;
			end
			cnt_q <= cnt_nx;
			if (cmd.ack_clr) begin
				found_q <= 1'b0;
				freed_q <= '0;
			end else begin
				if (cmd.match_take) begin
					found_q <= 1'b1;
				end
				if (cmd.free_slot) begin
					freed_q <= freed_q + CNT_W'(1);
				end
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

>>> design/retransmit_window_tracker.sv
// Top level of the retransmit window tracker: register port, sequencer, datapath.
//
// Usage: commands arrive on the in_valid/in_ready channel as in_item (tick,
// add sent packet, acknowledgement); results leave on out_valid/out_ready as
// out_item. A tick gives one resend per expired slot in ascending slot order
// and then a tick-done result; add and ack give one result each; the final
// result of a command carries last. Command code 3 is taken and dropped.
// One command at a time. An add is decided and its result loaded into the
// output register in the add state. A tick visits every slot once, skipping
// a free slot and reading then evaluating a valid one, then gives tick done.
// An ack walks the table once the same way, and a second time when its
// sequence matches. The pace is set by the single read port of the slot
// RAM, one slot per visit. in_ready rises again as soon as the last result
// is loaded into the output register.
// Stall: while a result waits in the output register the sequencer holds at
// the next result it has to produce; no result is lost or repeated.
// Reset: all slots free, timeout_ms = 4000; the slot RAM needs no clearing.
// The APB port holds timeout_ms at address 0; write it only while idle.
`timescale 1ns / 1ps
module retransmit_window_tracker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  rwt_pkg::in_item_t              in_item,
	output logic                           out_valid,
	input  logic                           out_ready,
	output rwt_pkg::out_item_t             out_item,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [rwt_pkg::PADDR_W-1:0]    paddr,
	input  logic [rwt_pkg::PDATA_W-1:0]    pwdata,
	output logic [rwt_pkg::PDATA_W-1:0]    prdata,
	output logic                           pready
);

	logic [rwt_pkg::TIMEOUT_W-1:0] timeout_q;
	logic                          reg_sel;
	rwt_pkg::dp_cmd_t              dp_cmd;
	rwt_pkg::dp_sts_t              dp_sts;

	assign pready  = 1'b1;
	assign reg_sel = (paddr[rwt_pkg::PADDR_W-1:2] == rwt_pkg::REG_TIMEOUT);
	assign prdata  = reg_sel ? rwt_pkg::PDATA_W'(timeout_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= rwt_pkg::TIMEOUT_RESET;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			timeout_q <= pwdata[rwt_pkg::TIMEOUT_W-1:0];
		end
	end

	rwt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_cmd   (in_item.cmd),
		.sts      (dp_sts),
		.in_ready (in_ready),
		.cmd      (dp_cmd)
	);

	rwt_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (dp_cmd),
		.in_item    (in_item),
		.timeout_ms (timeout_q),
		.out_ready  (out_ready),
		.out_valid  (out_valid),
		.out_item   (out_item),
		.sts        (dp_sts)
	);

endmodule

>>> design/rwt_checker.sv
// Port-level checker for the retransmit window tracker, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rwt_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input rwt_pkg::in_item_t  in_item,
	input logic               out_valid,
	input logic               out_ready,
	input rwt_pkg::out_item_t out_item
);

	`ASSERT_PROP(a_out_hold, clk, arst_n, out_valid && !out_ready |=> out_valid && $stable(out_item), "result changed or dropped while stalled")
	`ASSERT_PROP(a_mid_kind, clk, arst_n, out_valid && !out_item.last |-> out_item.kind == rwt_pkg::KIND_RESEND, "non-final result is not a resend")
	`ASSERT_PROP(a_mid_busy, clk, arst_n, out_valid && out_ready && !out_item.last |-> !in_ready, "new command taken before tick done")
	`ASSERT_NEVER(a_empty_free, clk, arst_n, out_valid && out_item.all_empty && !out_item.has_free, "empty table reported without a free slot")
	`ASSERT_PROP(a_tick_empty, clk, arst_n, out_valid && out_item.kind == rwt_pkg::KIND_TICK_DONE && out_item.all_empty |-> out_item.count == '0, "empty table with nonzero outstanding count")

endmodule

bind retransmit_window_tracker rwt_checker u_rwt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_item   (in_item),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_item  (out_item)
);
